// ----- hdl/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// SM4 package
// Shared types, constants and round functions for the SM4 block cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_IV_HIGH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IV_LOW   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECRYPT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CHAIN    = 3'd5;

    localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;       // take input block, prepare cipher input
        logic key_load;   // load key schedule state from key registers
        logic key_round;  // one key schedule step
        logic data_round; // one cipher round
        logic finish;     // form result and update chain
    } t_cmd;

    typedef logic [7:0] t_sbox [256];
    localparam t_sbox SBOX = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // CK word: byte j of word i is (4i+j)*7 mod 256.
    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'({i, 2'(j)}) * 8'd7;
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

// ----- hdl/sm4_ctrl.sv -----
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key expansion, the cipher rounds and the result hand-off.
// ----------------------------------------------------------------------------
module sm4_ctrl #(
    parameter int ROUND_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_keys_ready,
    output sm4_pkg::t_cmd     o_cmd,
    output logic [$clog2(ROUND_COUNT)-1:0] o_round
);
    import sm4_pkg::*;

    localparam int RW = $clog2(ROUND_COUNT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KEY   = 5'b00010,
        S_LOAD  = 5'b00100,
        S_ROUND = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_round, n_round;
    logic          last;

    assign last        = (r_round == RW'(ROUND_COUNT - 1));
    assign o_round     = r_round;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    if (i_keys_ready) begin
                        n_state = S_ROUND;
                    end else begin
                        o_cmd.key_load = 1'b1;
                        n_state        = S_KEY;
                    end
                end
            end
            S_KEY: begin
                o_cmd.key_round = 1'b1;
                n_round         = r_round + 1'b1;
                if (last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.data_round = 1'b1;
                n_round          = r_round + 1'b1;
                if (last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

endmodule

// ----- hdl/sm4_datapath.sv -----
// ----------------------------------------------------------------------------
// SM4 datapath
// Configuration registers, round key memory, round unit and CBC chaining.
// ----------------------------------------------------------------------------
module sm4_datapath #(
    parameter int ROUND_COUNT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [sm4_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [sm4_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [127:0]             i_block,
    input  logic [4:0]               i_byte_count,
    input  logic                     i_first_block,
    input  sm4_pkg::t_cmd            i_cmd,
    input  logic [$clog2(ROUND_COUNT)-1:0] i_round,
    output logic                     o_keys_ready,
    output logic [127:0]             o_result
);
    import sm4_pkg::*;

    localparam int RW = $clog2(ROUND_COUNT);

    logic [127:0] r_key, r_iv, r_chain, r_x, r_ks, r_in, r_res;
    logic         r_dec, r_cbc, r_keys_ready, r_dec_op, r_cbc_op;
    logic [4:0]   r_len;
    logic [31:0]  r_rk [ROUND_COUNT];
    logic [31:0]  r_rk_q;
    logic [RW-1:0] rk_addr;

    logic [127:0] cv, blk, tmp, fin, dec_x;
    logic [4:0]   len;
    logic [31:0]  kb, nk, xb, nx;

    assign o_keys_ready = r_keys_ready;
    assign o_result     = r_res;

    // Effective length: 0 and above 16 mean a full block.
    always_comb begin
        len = i_byte_count;
        if (len == 5'd0 || len > 5'd16) begin
            len = 5'd16;
        end
    end

    assign cv  = i_first_block ? r_iv : r_chain;
    assign blk = i_block;

    // Shifted chain bytes followed by message bytes, then XOR with chain.
    always_comb begin
        logic [127:0] mix;
        mix = (len == 5'd16) ? blk
            : ((cv << (8 * len)) | (blk >> (8 * (5'd16 - len))));
        tmp = mix ^ cv;
    end

    // Key schedule step.
    assign kb = tau(r_ks[95:64] ^ r_ks[63:32] ^ r_ks[31:0] ^ ck_word(5'(i_round)));
    assign nk = r_ks[127:96] ^ kb ^ rotl(kb, 13) ^ rotl(kb, 23);

    function automatic logic r_dec_op_next();
        return i_cmd.load ? r_dec : r_dec_op;
    endfunction

    // Read address for the next round: registered read data feeds the round.
    // Outside the cipher rounds the first round key is fetched.
    always_comb begin
        logic [RW-1:0] nxt;
        nxt = i_cmd.data_round ? i_round + 1'b1 : '0;
        rk_addr = r_dec_op_next() ? RW'(ROUND_COUNT - 1) - nxt : nxt;
    end

    assign xb = tau(r_x[95:64] ^ r_x[63:32] ^ r_x[31:0] ^ r_rk_q);
    assign nx = r_x[127:96] ^ xb ^ rotl(xb, 2) ^ rotl(xb, 10) ^ rotl(xb, 18) ^ rotl(xb, 24);

    // Final: output word order reversed, then CBC post-processing.
    always_comb begin
        logic [127:0] o;
        o     = {nx, r_x[31:0], r_x[63:32], r_x[95:64]};
        dec_x = o ^ r_chain;
        if (r_len != 5'd16) begin
            dec_x = (dec_x << (8 * (5'd16 - r_len))) | (dec_x & ({128{1'b1}} >> (8 * r_len)));
        end
        fin = !r_cbc_op ? o : (r_dec_op ? dec_x : o);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_iv         <= '0;
            r_dec        <= 1'b0;
            r_cbc        <= 1'b0;
            r_keys_ready <= 1'b0;
            r_chain      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY_HIGH: begin
                        r_key[127:64] <= i_cfg_data;
                        r_keys_ready  <= 1'b0;
                    end
                    REG_KEY_LOW: begin
                        r_key[63:0]  <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    REG_IV_HIGH: r_iv[127:64] <= i_cfg_data;
                    REG_IV_LOW:  r_iv[63:0]   <= i_cfg_data;
                    REG_DECRYPT: r_dec <= i_cfg_data[0];
                    REG_CHAIN:   r_cbc <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (r_cbc && r_dec) begin
                    r_chain <= i_block;
                end else begin
                    r_chain <= cv;
                end
            end
            if (i_cmd.key_round && i_round == RW'(ROUND_COUNT - 1)) begin
                r_keys_ready <= 1'b1;
            end
            if (i_cmd.finish && r_cbc_op && !r_dec_op) begin
                r_chain <= fin;
            end
        end
    end

    // Decryption XOR against the chain value seen at load time.
    function automatic logic [127:0] decx_fix(input logic [127:0] c);
        logic [127:0] d;
        d = {nx, r_x[31:0], r_x[63:32], r_x[95:64]} ^ c;
        if (r_len != 5'd16) begin
            d = (d << (8 * (5'd16 - r_len))) | (d & ({128{1'b1}} >> (8 * r_len)));
        end
        return d;
    endfunction

    // The chain used in decryption XOR must be the pre-load chain; hold it
    // in the input register slot instead.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec_op <= r_dec;
            r_cbc_op <= r_cbc;
            r_len    <= len;
            r_x      <= (r_cbc && !r_dec) ? tmp : blk;
            r_in     <= cv;
        end
        if (i_cmd.key_load) begin
            r_ks <= r_key ^ FK;
        end
        if (i_cmd.key_round) begin
            r_ks          <= {r_ks[95:0], nk};
            r_rk[i_round] <= nk;
        end
        if (i_cmd.data_round) begin
            r_x <= {r_x[95:0], nx};
        end
        if (i_cmd.finish) begin
            r_res <= (r_cbc_op && r_dec_op) ? decx_fix(r_in) : fin;
        end
        r_rk_q <= r_rk[rk_addr];
    end

endmodule

// ----- hdl/sm4_block_cipher_ecb_cbc.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher, ECB and CBC
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// Usage: configuration is written through i_cfg_we/i_cfg_index/i_cfg_data
// while the block is idle (key halves, IV halves, decrypt and chain modes).
// One 128-bit block is accepted per transfer on the slave stream; tdata
// holds block_high, block_low, byte_count and first_block from bit 0 up.
// The result block leaves on the master stream. An item is loaded on
// acceptance and then runs all its cipher rounds through a
// single shared round unit; after reset or a key change the first item
// also runs key expansion into the round key memory before its rounds.
// The block works on one item at a time: s_axis_tready is low until the
// result transfer completes, so a new item is accepted only after the
// previous result has been taken, and a stalled receiver holds the block. Reset
// clears all configuration, the chain value and the key-ready flag.
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc #(
    parameter int ROUND_COUNT = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits: block_high[63:0], block_low[127:64], byte_count[132:128],
    // first_block[133], zero pad up to 136
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits: result_high[63:0], result_low[127:64]
    output logic [127:0] m_axis_tdata
);
    import sm4_pkg::*;

    t_cmd                          cmd;
    logic [$clog2(ROUND_COUNT)-1:0] round;
    logic                          keys_ready;
    logic [127:0]                  res;

    sm4_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_keys_ready(keys_ready),
        .o_cmd       (cmd),
        .o_round     (round)
    );

    sm4_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_block      ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_byte_count (s_axis_tdata[132:128]),
        .i_first_block(s_axis_tdata[133]),
        .i_cmd        (cmd),
        .i_round      (round),
        .o_keys_ready (keys_ready),
        .o_result     (res)
    );

    assign m_axis_tdata = {res[63:0], res[127:64]};

endmodule

// ----- hdl/sm4_checker.sv -----
// ----------------------------------------------------------------------------
// SM4 port checker
// Checks the stream handshake behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module sm4_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted during processing");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##31 !m_axis_tvalid)
        else $error("result too early");
endmodule

bind sm4_block_cipher_ecb_cbc sm4_checker u_sm4_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ----- verif/sm4_block_cipher_ecb_cbc_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 ECB/CBC block cipher testbench
// Drives cipher blocks into the slave stream under several idling phases,
// predicts every result block with its own SM4 model (key schedule, rounds,
// CBC chaining and the short final block rules) and checks each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc_tb;
    import sm4_pkg::*;

    // One pending input block as it travels on the slave stream.
    typedef struct packed {
        logic [4:0]  count;
        logic        first;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
    } t_blk_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    sm4_block_cipher_ecb_cbc dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Predictor state: its own copy of the configuration and the chain.
    logic [63:0]  mdl_key_hi, mdl_key_lo, mdl_iv_hi, mdl_iv_lo;
    logic         mdl_decrypt, mdl_cbc;
    logic [31:0]  mdl_rk [32];
    logic [127:0] mdl_chain;

    t_blk_item    pending_blocks[$];
    logic [127:0] expected_blocks[$];
    int           sent_count;
    int           error_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    longint       cycle_count;

    function automatic logic [31:0] sbox_word(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Round keys from the current key registers; FK and CK are rebuilt here.
    task automatic build_round_keys();
        logic [31:0] k [4];
        logic [31:0] ck, b, nk;
        logic [7:0]  cb;
        k[0] = mdl_key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = mdl_key_hi[31:0]  ^ 32'h56aa3350;
        k[2] = mdl_key_lo[63:32] ^ 32'h677d9197;
        k[3] = mdl_key_lo[31:0]  ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++) begin
            ck = '0;
            for (int j = 0; j < 4; j++) begin
                cb = 8'((4 * i + j) * 7);
                ck = {ck[23:0], cb};
            end
            b = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
            mdl_rk[i] = nk;
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
        end
    endtask

    function automatic logic [127:0] sm4_rounds(input logic [127:0] src);
        logic [31:0] x [4];
        logic [31:0] rk, b, nx;
        for (int i = 0; i < 4; i++) x[i] = src[127 - 32 * i -: 32];
        for (int i = 0; i < 32; i++) begin
            rk = mdl_decrypt ? mdl_rk[31 - i] : mdl_rk[i];
            b = sbox_word(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // Works out the result block for one accepted input and moves the chain.
    // Blocks are kept as 128-bit vectors with byte 0 in the top bits.
    function automatic logic [127:0] cipher_result(input t_blk_item it);
        logic [127:0] blk, mixed, res, tmp;
        int len;
        blk = {it.blk_hi, it.blk_lo};
        len = (it.count == 0 || it.count > 16) ? 16 : int'(it.count);
        if (it.first) mdl_chain = {mdl_iv_hi, mdl_iv_lo};
        if (!mdl_cbc) begin
            res = sm4_rounds(blk);
        end else if (!mdl_decrypt) begin
            // Short block: chain bytes len..15, then the first len message bytes.
            for (int i = 0; i < 16; i++) begin
                if (i < 16 - len) mixed[127 - 8 * i -: 8] = mdl_chain[127 - 8 * (len + i) -: 8];
                else mixed[127 - 8 * i -: 8] = blk[127 - 8 * (i - (16 - len)) -: 8];
            end
            res = sm4_rounds(mixed ^ mdl_chain);
            mdl_chain = res;
        end else begin
            res = sm4_rounds(blk) ^ mdl_chain;
            mdl_chain = blk;
            // Short block: the last len bytes move to the front.
            tmp = res;
            for (int i = 0; i < len; i++)
                res[127 - 8 * i -: 8] = tmp[127 - 8 * (16 - len + i) -: 8];
        end
        return res;
    endfunction

    // Driver: idles at random and keeps tvalid steady while a transfer waits.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            s_axis_tvalid <= 1'b1;
        end else if (pending_blocks.size() > 0 &&
                     $urandom_range(99) >= sender_idle_pct) begin
            t_blk_item it;
            it = pending_blocks.pop_front();
            expected_blocks.push_back(cipher_result(it));
            s_axis_tdata  <= {2'b00, it.first, it.count, it.blk_lo, it.blk_hi};
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) sent_count <= sent_count + 1;
    end

    // Monitor: random back-pressure and checking of each result transfer.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= receiver_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                logic [127:0] want;
                want = expected_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64]) begin
                    $display("%0t: result_high mismatch, expected %h, actual %h",
                             $time, want[127:64], m_axis_tdata[63:0]);
                    error_count++;
                end
                if (m_axis_tdata[127:64] !== want[63:0]) begin
                    $display("%0t: result_low mismatch, expected %h, actual %h",
                             $time, want[63:0], m_axis_tdata[127:64]);
                    error_count++;
                end
            end
        end
        if (cycle_count > 1500000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Register write at one clock edge; the predictor follows immediately.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_KEY_HIGH: begin mdl_key_hi = val; build_round_keys(); end
            REG_KEY_LOW:  begin mdl_key_lo = val; build_round_keys(); end
            REG_IV_HIGH:  mdl_iv_hi = val;
            REG_IV_LOW:   mdl_iv_lo = val;
            REG_DECRYPT:  mdl_decrypt = val[0];
            REG_CHAIN:    mdl_cbc = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Biased field values so that all-zero and all-one blocks come up.
    function automatic logic [63:0] pick64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic t_blk_item make_block(input logic first, input logic [4:0] cnt);
        t_blk_item it;
        it.blk_hi = pick64();
        it.blk_lo = pick64();
        it.first  = first;
        it.count  = cnt;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_blocks.size() > 0 || expected_blocks.size() > 0) @(posedge i_clk);
        // A result left in flight still holds the block; let it settle.
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct);
        int left;
        int msg_len;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        left = n_items;
        while (left > 0) begin
            // Messages: first block flagged, full blocks, often a short last block.
            msg_len = $urandom_range(1, 6);
            for (int i = 0; i < msg_len && left > 0; i++, left--) begin
                logic [4:0] cnt;
                cnt = 5'd16;
                if (i == msg_len - 1 && $urandom_range(2) == 0)
                    cnt = 5'($urandom_range(1, 15));
                if ($urandom_range(19) == 0) cnt = 5'($urandom_range(31));
                pending_blocks.push_back(make_block(i == 0 || $urandom_range(29) == 0, cnt));
            end
        end
        wait_drained();
    endtask

    task automatic set_modes(input logic dec, input logic cbc);
        write_reg(REG_DECRYPT, {63'd0, dec});
        write_reg(REG_CHAIN, {63'd0, cbc});
    endtask

    initial begin
        int phase;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        sent_count    = 0;
        error_count   = 0;
        cycle_count   = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mdl_key_hi = '0; mdl_key_lo = '0; mdl_iv_hi = '0; mdl_iv_lo = '0;
        mdl_decrypt = 1'b0; mdl_cbc = 1'b0; mdl_chain = '0;
        build_round_keys();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the standard test vector, then each mode and short blocks.
        write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(REG_KEY_LOW,  64'hfedcba9876543210);
        write_reg(REG_IV_HIGH,  '1);
        write_reg(REG_IV_LOW,   '0);
        pending_blocks.push_back('{5'd16, 1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210});
        pending_blocks.push_back('{5'd0,  1'b1, 64'h0, 64'h0});
        pending_blocks.push_back('{5'd31, 1'b0, '1, '1});
        wait_drained();
        for (int m = 0; m < 4; m++) begin
            set_modes(m[1], m[0]);
            pending_blocks.push_back(make_block(1'b1, 5'd16));
            pending_blocks.push_back(make_block(1'b0, 5'd16));
            pending_blocks.push_back(make_block(1'b0, 5'd1));
            pending_blocks.push_back(make_block(1'b0, 5'd15));
            pending_blocks.push_back(make_block(1'b0, 5'd17));
            wait_drained();
        end
        // Mode change in the middle of a message keeps the chain.
        set_modes(1'b0, 1'b1);
        pending_blocks.push_back(make_block(1'b1, 5'd16));
        wait_drained();
        set_modes(1'b1, 1'b1);
        pending_blocks.push_back(make_block(1'b0, 5'd7));
        wait_drained();

        // Random phases: each with a fresh key, IV and mode, under the four
        // idling patterns in turn.
        for (phase = 0; phase < 16; phase++) begin
            write_reg(REG_KEY_HIGH, pick64());
            write_reg(REG_KEY_LOW,  pick64());
            write_reg(REG_IV_HIGH,  pick64());
            write_reg(REG_IV_LOW,   pick64());
            set_modes(1'($urandom_range(1)), $urandom_range(3) != 0);
            case (phase % 4)
                0: random_phase(88, 0, 0);
                1: random_phase(88, 78, 0);
                2: random_phase(88, 0, 78);
                default: random_phase(88, 17, 17);
            endcase
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/sm4_pkg.sv
hdl/sm4_ctrl.sv
hdl/sm4_datapath.sv
hdl/sm4_block_cipher_ecb_cbc.sv
hdl/sm4_checker.sv
verif/sm4_block_cipher_ecb_cbc_tb.sv
